/* rtl/irs_pkg.sv */
`default_nettype none

package irs_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int NUM_LANES       = 7;
  localparam int SPIKE_W         = 8;
  localparam int PHASE_W         = 3;
  localparam int CH_W            = 7;

  localparam logic [SPIKE_W-1:0] SPIKE_RESET = 8'd5;

  localparam logic [PHASE_W-1:0] PH_DARK0 = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LIT1  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DARK2 = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LIT3  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DARK4 = 3'd4;
  localparam logic [PHASE_W-1:0] PH_LIT5  = 3'd5;

  localparam logic [CH_W-1:0] LED_OFF    = 7'h00;
  localparam logic [CH_W-1:0] LED_LIT1   = 7'h12;
  localparam logic [CH_W-1:0] LED_LIT3   = 7'h64;
  localparam logic [CH_W-1:0] LED_LIT5   = 7'h09;
  localparam logic [CH_W-1:0] MASK_DARK0 = 7'h1B;
  localparam logic [CH_W-1:0] MASK_DARK2 = 7'h6D;
  localparam logic [CH_W-1:0] MASK_DARK4 = 7'h76;

  // Division by ten is a multiplication by ceil(2^23 / 10); it is exact for
  // every operand below 2^20, which covers all sample widths in range.
  localparam int                  RECIP_W     = 20;
  localparam int                  RECIP_SHIFT = 23;
  localparam logic [RECIP_W-1:0]  RECIP10     = 20'd838861;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_SCALE7,
    KIND_SCALE6,
    KIND_HALF
  } lane_kind_e;

  // Lane k owns ambient, previous difference and level k.
  localparam lane_kind_e LANE_KIND [NUM_LANES] = '{
    KIND_PLAIN, KIND_PLAIN, KIND_PLAIN, KIND_PLAIN, KIND_SCALE7, KIND_SCALE6, KIND_HALF
  };
  localparam int LANE_SRC [NUM_LANES] = '{4, 3, 2, 1, 0, 5, 6};
  localparam logic [PHASE_W-1:0] LANE_DARK [NUM_LANES] = '{
    PH_DARK0, PH_DARK2, PH_DARK4, PH_DARK0, PH_DARK2, PH_DARK4, PH_DARK4
  };

  typedef struct packed {
    logic               acc;
    logic [PHASE_W-1:0] phase;
    logic               ld1;
    logic               ld2;
    logic               ld3;
    logic               commit;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

/* rtl/irs_sample_if.sv */
`default_nettype none

interface irs_sample_if import irs_pkg::*; #(
  parameter int SampleBits = SAMPLE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] adc_ch0;
  logic [SampleBits-1:0] adc_ch1;
  logic [SampleBits-1:0] adc_ch2;
  logic [SampleBits-1:0] adc_ch3;
  logic [SampleBits-1:0] adc_ch4;
  logic [SampleBits-1:0] adc_ch5;
  logic [SampleBits-1:0] adc_ch6;

  modport source (
    output valid, adc_ch0, adc_ch1, adc_ch2, adc_ch3, adc_ch4, adc_ch5, adc_ch6,
    input  ready
  );
  modport sink (
    input  valid, adc_ch0, adc_ch1, adc_ch2, adc_ch3, adc_ch4, adc_ch5, adc_ch6,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/irs_result_if.sv */
`default_nettype none

interface irs_result_if import irs_pkg::*; #(
  parameter int SampleBits = SAMPLE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [CH_W-1:0]       led_drive;
  logic [CH_W-1:0]       adc_select;
  logic [SampleBits-1:0] level_0;
  logic [SampleBits-1:0] level_1;
  logic [SampleBits-1:0] level_2;
  logic [SampleBits-1:0] level_3;
  logic [SampleBits-1:0] level_4;
  logic [SampleBits-1:0] level_5;
  logic [SampleBits-1:0] level_6;

  modport source (
    output valid, led_drive, adc_select,
           level_0, level_1, level_2, level_3, level_4, level_5, level_6,
    input  ready
  );
  modport sink (
    input  valid, led_drive, adc_select,
           level_0, level_1, level_2, level_3, level_4, level_5, level_6,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/irs_cfg_if.sv */
`default_nettype none

interface irs_cfg_if import irs_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SPIKE_W-1:0] spike_limit;

  modport source (output valid, spike_limit, input ready);
  modport sink (input valid, spike_limit, output ready);
endinterface

`default_nettype wire

/* rtl/irs_lane.sv */
`default_nettype none

module irs_lane import irs_pkg::*; #(
  parameter int SampleBits = SAMPLE_BITS_DEF,
  parameter int Lane       = 0
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire pipe_ctrl_t                   ctrl_i,
  input  wire logic [SampleBits-1:0]        sample_i,
  input  wire logic [SPIKE_W-1:0]           spike_limit_i,
  output logic signed [SampleBits+1:0]      level_o
);

  localparam lane_kind_e         Kind   = LANE_KIND[Lane];
  localparam logic [PHASE_W-1:0] DarkPh = LANE_DARK[Lane];
  localparam logic [PHASE_W-1:0] LitPh  = DarkPh + PHASE_W'(1);
  localparam bit                 Leaky  = (Kind == KIND_SCALE6) || (Kind == KIND_HALF);
  localparam int                 DW     = SampleBits + 1;
  localparam int                 LW     = SampleBits + 2;
  localparam int                 VW     = SampleBits + 3;
  localparam int                 PW     = VW + RECIP_SHIFT;

  logic [SampleBits-1:0]    ambient_q;
  logic signed [DW-1:0]     prev_q;
  logic signed [LW-1:0]     level_q, level_d;

  // Stage 1: magnitude and sign of the ambient-subtracted sample.
  logic signed [DW-1:0]     diff1, neg1;
  logic [SampleBits-1:0]    mag1_d, mag1_q;
  logic                     sgn1_q, upd1_q;

  assign diff1  = $signed({1'b0, sample_i}) - $signed({1'b0, ambient_q});
  assign neg1   = -diff1;
  assign mag1_d = diff1[DW-1] ? neg1[SampleBits-1:0] : diff1[SampleBits-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld1) begin
      mag1_q <= mag1_d;
      sgn1_q <= diff1[DW-1];
      upd1_q <= (ctrl_i.phase == LitPh);
    end
  end

  // Stage 2: first division by ten.
  logic [VW-1:0]            v2;
  logic [PW-1:0]            prod2_q;
  logic [SampleBits-1:0]    mag2_q;
  logic                     sgn2_q, upd2_q;

  always_comb begin
    if (Kind == KIND_SCALE6) begin
      v2 = VW'({mag1_q, 2'b00}) + VW'({mag1_q, 1'b0});
    end else begin
      v2 = VW'(mag1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld2) begin
      prod2_q <= PW'(v2) * PW'(RECIP10);
      mag2_q  <= mag1_q;
      sgn2_q  <= sgn1_q;
      upd2_q  <= upd1_q;
    end
  end

  // Stage 3: second division by ten for the seven-tenths channel.
  logic [VW-1:0]            q3, q7;
  logic [VW-1:0]            q3_q;
  logic [PW-1:0]            prod3_q;
  logic [SampleBits-1:0]    mag3_q;
  logic                     sgn3_q, upd3_q;

  assign q3 = prod2_q[RECIP_SHIFT +: VW];
  assign q7 = q3 * VW'(7);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld3) begin
      q3_q    <= q3;
      prod3_q <= PW'(q7) * PW'(RECIP10);
      mag3_q  <= mag2_q;
      sgn3_q  <= sgn2_q;
      upd3_q  <= upd2_q;
    end
  end

  // Final step: signed difference, spike test and level update.
  logic [VW-1:0]            rv;
  logic signed [DW-1:0]     pos4, diff4;
  logic signed [DW:0]       dev, neg_dev;
  logic [DW:0]              abs_dev, spike_ext;
  logic signed [LW-1:0]     lvl_adj, half, leak, new_level;

  always_comb begin
    case (Kind)
      KIND_PLAIN:  rv = q3_q;
      KIND_SCALE7: rv = prod3_q[RECIP_SHIFT +: VW];
      KIND_SCALE6: rv = q3_q >> 1;
      KIND_HALF:   rv = VW'(mag3_q) >> 1;
      default:     rv = q3_q;
    endcase
  end

  assign pos4      = $signed({1'b0, rv[SampleBits-1:0]});
  assign diff4     = sgn3_q ? -pos4 : pos4;
  assign dev       = $signed({prev_q[DW-1], prev_q}) - $signed({diff4[DW-1], diff4});
  assign neg_dev   = -dev;
  assign abs_dev   = dev[DW] ? neg_dev : dev;
  assign spike_ext = {{(DW + 1 - SPIKE_W){1'b0}}, spike_limit_i};

  // Halving truncates toward zero, so a negative level is rounded up first.
  assign lvl_adj   = level_q + $signed({{(LW-1){1'b0}}, level_q[LW-1]});
  assign half      = lvl_adj >>> 1;
  assign leak      = $signed({diff4[DW-1], diff4}) + half;
  assign new_level = Leaky ? leak : $signed({diff4[DW-1], diff4});

  always_comb begin
    level_d = level_q;
    if (ctrl_i.commit && upd3_q && (abs_dev <= spike_ext)) begin
      level_d = new_level;
    end
  end

  assign level_o = level_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ambient_q <= '0;
      prev_q    <= '0;
      level_q   <= '0;
    end else begin
      if (ctrl_i.acc && (ctrl_i.phase == DarkPh)) begin
        ambient_q <= sample_i;
      end
      if (ctrl_i.commit && upd3_q) begin
        prev_q <= diff4;
      end
      level_q <= level_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/irs_merge.sv */
`default_nettype none

module irs_merge import irs_pkg::*; #(
  parameter int SampleBits = SAMPLE_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire pipe_ctrl_t                 ctrl_i,
  input  wire logic [PHASE_W-1:0]         phase_i,
  input  wire logic signed [SampleBits+1:0] level_i [NUM_LANES],
  output logic [CH_W-1:0]                 led_o,
  output logic [CH_W-1:0]                 select_o,
  output logic [SampleBits-1:0]           level_o [NUM_LANES]
);

  logic [CH_W-1:0]       mask_q, mask_d;
  logic [CH_W-1:0]       led_d;
  logic [SampleBits-1:0] clamp [NUM_LANES];

  always_comb begin
    mask_d = mask_q;
    led_d  = LED_OFF;
    case (phase_i)
      PH_DARK0: mask_d = MASK_DARK0;
      PH_LIT1:  led_d  = LED_LIT1;
      PH_DARK2: mask_d = MASK_DARK2;
      PH_LIT3:  led_d  = LED_LIT3;
      PH_DARK4: mask_d = MASK_DARK4;
      PH_LIT5:  led_d  = LED_LIT5;
      default:  mask_d = mask_q;
    endcase
  end

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      if (level_i[k][SampleBits+1]) begin
        clamp[k] = '0;
      end else if (level_i[k][SampleBits]) begin
        clamp[k] = '1;
      end else begin
        clamp[k] = level_i[k][SampleBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (ctrl_i.commit) begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      led_o    <= led_d;
      select_o <= mask_d;
      level_o  <= clamp;
    end
  end

endmodule

`default_nettype wire

/* rtl/ir_sensor_sequencer.sv */
// Throughput: one request per cycle through three lane stages and the result
// register; ready falls only when the result is held and all stages are full.
// Reset (asynchronous, active low): phase 0, ambients, differences, levels and
// channel mask cleared, spike limit 5, pipeline empty.
`default_nettype none

module ir_sensor_sequencer import irs_pkg::*; #(
  parameter int SampleBits = SAMPLE_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  irs_sample_if.sink  sample_i,
  irs_cfg_if.sink     cfg_i,
  irs_result_if.source result_o
);

  logic [SPIKE_W-1:0]    spike_q;
  logic [PHASE_W-1:0]    phase_q, phase_d;
  logic [PHASE_W-1:0]    ph1_q, ph2_q, ph3_q;
  logic                  v1_q, v2_q, v3_q, vout_q;
  logic                  ld1, ld2, ld3, ld_out, acc;
  pipe_ctrl_t            ctrl;
  logic [SampleBits-1:0] samples [NUM_LANES];
  logic signed [SampleBits+1:0] lane_level [NUM_LANES];
  logic [SampleBits-1:0] out_level [NUM_LANES];

  // Each stage loads when it is empty or its contents move on.
  assign ld_out = !vout_q || result_o.ready;
  assign ld3    = !v3_q || ld_out;
  assign ld2    = !v2_q || ld3;
  assign ld1    = !v1_q || ld2;
  assign acc    = sample_i.valid && ld1;

  assign sample_i.ready = ld1;
  assign cfg_i.ready    = 1'b1;
  assign result_o.valid = vout_q;

  assign ctrl.acc    = acc;
  assign ctrl.phase  = phase_q;
  assign ctrl.ld1    = ld1;
  assign ctrl.ld2    = ld2;
  assign ctrl.ld3    = ld3;
  assign ctrl.commit = v3_q && ld_out;

  always_comb begin
    case (phase_q)
      PH_DARK0: phase_d = PH_LIT1;
      PH_LIT1:  phase_d = PH_DARK2;
      PH_DARK2: phase_d = PH_LIT3;
      PH_LIT3:  phase_d = PH_DARK4;
      PH_DARK4: phase_d = PH_LIT5;
      default:  phase_d = PH_DARK0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spike_q <= SPIKE_RESET;
      phase_q <= PH_DARK0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      vout_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        spike_q <= cfg_i.spike_limit;
      end
      if (acc) begin
        phase_q <= phase_d;
      end
      if (ld1) begin
        v1_q <= acc;
      end
      if (ld2) begin
        v2_q <= v1_q;
      end
      if (ld3) begin
        v3_q <= v2_q;
      end
      if (ld_out) begin
        vout_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      ph1_q <= phase_q;
    end
    if (ld2) begin
      ph2_q <= ph1_q;
    end
    if (ld3) begin
      ph3_q <= ph2_q;
    end
  end

  assign samples[0] = sample_i.adc_ch0;
  assign samples[1] = sample_i.adc_ch1;
  assign samples[2] = sample_i.adc_ch2;
  assign samples[3] = sample_i.adc_ch3;
  assign samples[4] = sample_i.adc_ch4;
  assign samples[5] = sample_i.adc_ch5;
  assign samples[6] = sample_i.adc_ch6;

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    irs_lane #(
      .SampleBits (SampleBits),
      .Lane       (k)
    ) u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .sample_i      (samples[LANE_SRC[k]]),
      .spike_limit_i (spike_q),
      .level_o       (lane_level[k])
    );
  end

  irs_merge #(
    .SampleBits (SampleBits)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .phase_i  (ph3_q),
    .level_i  (lane_level),
    .led_o    (result_o.led_drive),
    .select_o (result_o.adc_select),
    .level_o  (out_level)
  );

  assign result_o.level_0 = out_level[0];
  assign result_o.level_1 = out_level[1];
  assign result_o.level_2 = out_level[2];
  assign result_o.level_3 = out_level[3];
  assign result_o.level_4 = out_level[4];
  assign result_o.level_5 = out_level[5];
  assign result_o.level_6 = out_level[6];

endmodule

`default_nettype wire

/* rtl/irs_checker.sv */
`default_nettype none

module irs_checker import irs_pkg::*; (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_ready_i,
  input wire logic            out_valid_i,
  input wire logic            out_ready_i,
  input wire logic [CH_W-1:0] led_i,
  input wire logic [CH_W-1:0] select_i
);

  logic       in_fire, out_fire;
  logic [2:0] occ_q, occ_d;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  always_comb begin
    occ_d = occ_q;
    if (in_fire && !out_fire) begin
      occ_d = occ_q + 3'd1;
    end else if (!in_fire && out_fire) begin
      occ_d = occ_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(led_i) && $stable(select_i))
    else $error("result request changed while stalled");

  a_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (select_i == MASK_DARK0) || (select_i == MASK_DARK2) ||
                    (select_i == MASK_DARK4))
    else $error("channel select is not a dark-phase mask");

  a_led_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (led_i == LED_OFF) ||
                    ((led_i == LED_LIT1) && (select_i == MASK_DARK0)) ||
                    ((led_i == LED_LIT3) && (select_i == MASK_DARK2)) ||
                    ((led_i == LED_LIT5) && (select_i == MASK_DARK4)))
    else $error("emitter drive does not match the channel select");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= 3'd4)
    else $error("more requests in flight than the pipeline holds");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> occ_q != 3'd0)
    else $error("result offered with no request in flight");

endmodule

bind ir_sensor_sequencer irs_checker u_irs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .led_i       (result_o.led_drive),
  .select_i    (result_o.adc_select)
);

`default_nettype wire

/* tb/irs_level_check.sv */
`default_nettype none

module irs_level_check import irs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  irs_sample_if     smp_mon,
  irs_cfg_if        cfg_mon,
  irs_result_if     res_mon,
  output int        fail_count_o,
  output int        pending_o,
  output int        checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB   = SAMPLE_BITS_DEF;
  localparam int SMAX = (1 << SB) - 1;

  typedef logic [NUM_LANES-1:0][SB-1:0] adc_tick_t;

  typedef struct packed {
    logic [CH_W-1:0]  led_drive;
    logic [CH_W-1:0]  adc_select;
    adc_tick_t        level;
  } reading_t;

  reading_t reading_q [$];

  // Shadow of the sequencer state.
  logic [PHASE_W-1:0]   seq_phase;
  logic [SB-1:0]        dark_ref   [NUM_LANES];
  logic signed [SB:0]   last_diff  [NUM_LANES];
  logic signed [SB+1:0] lane_level [NUM_LANES];
  logic [CH_W-1:0]      sel_mask;
  logic [SPIKE_W-1:0]   spike_lim;

  int errors  = 0;
  int matched = 0;

  // A new difference only moves the level when it stays within the spike limit
  // of the previous one; the previous difference is replaced regardless.
  function automatic void settle_lane(int lane, int diff, bit leaky);
    int dev;
    dev = int'(last_diff[lane]) - diff;
    if (dev < 0) dev = -dev;
    if (dev <= int'(spike_lim)) begin
      lane_level[lane] = (SB+2)'(leaky ? diff + int'(lane_level[lane]) / 2 : diff);
    end
    last_diff[lane] = (SB+1)'(diff);
  endfunction

  function automatic reading_t predict_reading(adc_tick_t adc);
    int       a [NUM_LANES];
    int       v;
    reading_t r;
    for (int k = 0; k < NUM_LANES; k++) a[k] = int'(adc[k]);
    r.led_drive = LED_OFF;
    case (seq_phase)
      PH_DARK0: begin
        dark_ref[0] = adc[4];
        dark_ref[3] = adc[1];
        sel_mask    = MASK_DARK0;
        seq_phase   = PH_LIT1;
      end
      PH_LIT1: begin
        settle_lane(0, (a[4] - int'(dark_ref[0])) / 10, 1'b0);
        settle_lane(3, (a[1] - int'(dark_ref[3])) / 10, 1'b0);
        r.led_drive = LED_LIT1;
        seq_phase   = PH_DARK2;
      end
      PH_DARK2: begin
        dark_ref[1] = adc[3];
        dark_ref[4] = adc[0];
        sel_mask    = MASK_DARK2;
        seq_phase   = PH_LIT3;
      end
      PH_LIT3: begin
        settle_lane(1, (a[3] - int'(dark_ref[1])) / 10, 1'b0);
        settle_lane(4, ((a[0] - int'(dark_ref[4])) / 10) * 7 / 10, 1'b0);
        r.led_drive = LED_LIT3;
        seq_phase   = PH_DARK4;
      end
      PH_DARK4: begin
        dark_ref[2] = adc[2];
        dark_ref[5] = adc[5];
        dark_ref[6] = adc[6];
        sel_mask    = MASK_DARK4;
        seq_phase   = PH_LIT5;
      end
      PH_LIT5: begin
        settle_lane(2, (a[2] - int'(dark_ref[2])) / 10, 1'b0);
        settle_lane(5, ((a[5] - int'(dark_ref[5])) * 6 / 10) / 2, 1'b1);
        settle_lane(6, (a[6] - int'(dark_ref[6])) / 2, 1'b1);
        r.led_drive = LED_LIT5;
        seq_phase   = PH_DARK0;
      end
      default: begin
        seq_phase = PH_DARK0;
      end
    endcase
    r.adc_select = sel_mask;
    for (int k = 0; k < NUM_LANES; k++) begin
      v = int'(lane_level[k]);
      if (v < 0) v = 0;
      if (v > SMAX) v = SMAX;
      r.level[k] = SB'(v);
    end
    return r;
  endfunction

  function automatic void compare_field(string fname, logic [SB-1:0] want, logic [SB-1:0] got);
    if (want !== got) begin
      errors++;
      $error("%s: expected %0d, got %0d", fname, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t  want;
    adc_tick_t got_level;
    if (!rst_ni) begin
      seq_phase = PH_DARK0;
      sel_mask  = '0;
      spike_lim = SPIKE_RESET;
      for (int k = 0; k < NUM_LANES; k++) begin
        dark_ref[k]   = '0;
        last_diff[k]  = '0;
        lane_level[k] = '0;
      end
      reading_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) spike_lim = cfg_mon.spike_limit;
      if (smp_mon.valid && smp_mon.ready) begin
        reading_q.push_back(predict_reading({smp_mon.adc_ch6, smp_mon.adc_ch5,
                                             smp_mon.adc_ch4, smp_mon.adc_ch3,
                                             smp_mon.adc_ch2, smp_mon.adc_ch1,
                                             smp_mon.adc_ch0}));
      end
      if (res_mon.valid && res_mon.ready) begin
        if (reading_q.size() == 0) begin
          errors++;
          $error("Result accepted with no request outstanding.");
        end else begin
          want      = reading_q.pop_front();
          got_level = {res_mon.level_6, res_mon.level_5, res_mon.level_4, res_mon.level_3,
                       res_mon.level_2, res_mon.level_1, res_mon.level_0};
          compare_field("led_drive", SB'(want.led_drive), SB'(res_mon.led_drive));
          compare_field("adc_select", SB'(want.adc_select), SB'(res_mon.adc_select));
          for (int k = 0; k < NUM_LANES; k++) begin
            compare_field($sformatf("level_%0d", k), want.level[k], got_level[k]);
          end
          matched++;
        end
      end
    end
    fail_count_o <= errors;
    pending_o    <= reading_q.size();
    checked_o    <= matched;
  end

endmodule

`default_nettype wire

/* tb/ir_sensor_sequencer_tb.sv */
`default_nettype none

module ir_sensor_sequencer_tb import irs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int SMAX        = (1 << SB) - 1;
  localparam int PER_SETTING = 178;
  localparam int NUM_SETTING = 8;

  typedef logic [NUM_LANES-1:0][SB-1:0] adc_tick_t;
  typedef enum {RDY_ALWAYS, RDY_PATTERN, RDY_RANDOM} rdy_mode_e;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  rdy_mode_e rdy_mode  = RDY_ALWAYS;
  logic [15:0] stall_pat = 16'b1101_1001_1110_0111;

  int tick_count   = 0;
  int limit_writes = 0;
  int fail_count;
  int pending;
  int checked;
  bit stuck = 1'b0;

  // Slowly drifting scene: ambient light and reflectance per analogue channel.
  int scene_amb  [NUM_LANES];
  int scene_refl [NUM_LANES];

  irs_sample_if smp ();
  irs_cfg_if    cfg ();
  irs_result_if res ();

  ir_sensor_sequencer dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp),
    .cfg_i    (cfg),
    .result_o (res)
  );

  irs_level_check level_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .smp_mon      (smp),
    .cfg_mon      (cfg),
    .res_mon      (res),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    stall_pat <= {stall_pat[0], stall_pat[15:1]};
    case (rdy_mode)
      RDY_ALWAYS:  res.ready <= 1'b1;
      RDY_PATTERN: res.ready <= stall_pat[0];
      default:     res.ready <= 1'($urandom_range(1));
    endcase
  end

  task automatic push_tick(adc_tick_t t);
    @(negedge clk_i);
    smp.valid   <= 1'b1;
    smp.adc_ch0 <= t[0];
    smp.adc_ch1 <= t[1];
    smp.adc_ch2 <= t[2];
    smp.adc_ch3 <= t[3];
    smp.adc_ch4 <= t[4];
    smp.adc_ch5 <= t[5];
    smp.adc_ch6 <= t[6];
    do @(posedge clk_i); while (!smp.ready);
    tick_count++;
  endtask

  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk_i);
      smp.valid <= 1'b0;
    end
  endtask

  // Stops requesting and waits until every outstanding result has come back.
  task automatic drain();
    int guard;
    guard = 0;
    hold_off(1);
    while (pending != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending != 0) begin
      stuck = 1'b1;
      $error("%0d results still outstanding after draining.", pending);
    end
  endtask

  task automatic write_limit(logic [SPIKE_W-1:0] lim);
    drain();
    @(negedge clk_i);
    cfg.valid       <= 1'b1;
    cfg.spike_limit <= lim;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
    limit_writes++;
  endtask

  // One full six-phase period with every channel at one value in the dark
  // phases and another in the lit phases.
  task automatic dark_lit_cycle(int dark_v, int lit_v);
    adc_tick_t t;
    repeat (6) begin
      for (int c = 0; c < NUM_LANES; c++) begin
        t[c] = SB'(((tick_count % 6) % 2 == 1) ? lit_v : dark_v);
      end
      push_tick(t);
    end
  endtask

  task automatic next_tick();
    adc_tick_t t;
    int        pick;
    int        v;
    bit        lit;
    pick = $urandom_range(99);
    lit  = (tick_count % 6) % 2 == 1;
    if (tick_count % 6 == 0) begin
      for (int c = 0; c < NUM_LANES; c++) begin
        if ($urandom_range(19) == 0) begin
          scene_amb[c]  = $urandom_range(SMAX);
          scene_refl[c] = int'($urandom_range(3200)) - 700;
        end else begin
          scene_amb[c]  += int'($urandom_range(8)) - 4;
          scene_refl[c] += int'($urandom_range(12)) - 6;
        end
      end
    end
    for (int c = 0; c < NUM_LANES; c++) begin
      if (pick < 15) begin
        t[c] = SB'($urandom_range(SMAX));
      end else if (pick < 20) begin
        t[c] = SB'($urandom_range(1) ? SMAX : 0);
      end else begin
        v = scene_amb[c] + int'($urandom_range(6)) - 3;
        if (lit) begin
          v += scene_refl[c];
          // Occasional glint that the spike filter should reject.
          if ($urandom_range(24) == 0) begin
            v += $urandom_range(1) ? int'($urandom_range(1500, 200))
                                   : -int'($urandom_range(1500, 200));
          end
        end
        if (v < 0) v = 0;
        if (v > SMAX) v = SMAX;
        t[c] = SB'(v);
      end
    end
    push_tick(t);
  endtask

  initial begin
    int        burst;
    int        sent;
    bit        steady;
    logic [SPIKE_W-1:0] lim;
    rst_ni          = 1'b0;
    smp.valid       = 1'b0;
    smp.adc_ch0     = '0;
    smp.adc_ch1     = '0;
    smp.adc_ch2     = '0;
    smp.adc_ch3     = '0;
    smp.adc_ch4     = '0;
    smp.adc_ch5     = '0;
    smp.adc_ch6     = '0;
    cfg.valid       = 1'b0;
    cfg.spike_limit = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // With the reset spike limit: a full-scale jump is first rejected as a
    // spike, then accepted; the reverse drives every level negative.
    dark_lit_cycle(0, SMAX);
    dark_lit_cycle(0, SMAX);
    dark_lit_cycle(SMAX, 0);
    dark_lit_cycle(SMAX, 0);

    for (int c = 0; c < NUM_LANES; c++) begin
      scene_amb[c]  = $urandom_range(SMAX);
      scene_refl[c] = int'($urandom_range(3200)) - 700;
    end

    for (int s = 0; s < NUM_SETTING; s++) begin
      case (s % 4)
        0:       lim = '0;
        1:       lim = '1;
        2:       lim = SPIKE_W'($urandom_range(12, 1));
        default: lim = SPIKE_W'($urandom_range(255));
      endcase
      write_limit(lim);
      rdy_mode = (s == 0) ? RDY_ALWAYS : rdy_mode_e'($urandom_range(2));
      steady   = (s == 0) || ($urandom_range(3) == 0);
      sent     = 0;
      while (sent < PER_SETTING) begin
        burst = $urandom_range(16, 1);
        repeat (burst) begin
          next_tick();
          sent++;
        end
        if (!steady) hold_off($urandom_range(6));
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d sensor ticks across the reset spike limit and %0d written settings.",
             tick_count, limit_writes);
    $display("Compared %0d results field by field; %0d mismatches seen.", checked, fail_count);
    if (fail_count == 0 && pending == 0 && !stuck) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("Run stopped by the watchdog before the stimulus completed.");
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
